[rtl/json_token_syntax_checker_unit_macros.svh]
// Assertion macros used by the token syntax checker RTL.
`ifndef JSON_TOKEN_SYNTAX_CHECKER_UNIT_MACROS_SVH
`define JSON_TOKEN_SYNTAX_CHECKER_UNIT_MACROS_SVH

// Check in the same cycle that the condition holds.
`define JTSC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("jtsc: same-cycle check failed");

// Check in the cycle that follows the condition.
`define JTSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("jtsc: next-cycle check failed");

`endif

[rtl/jtsc_pkg.sv]
// Package of types, codes and constants for the token syntax checker.
`default_nettype none
package jtsc_pkg;

    localparam int MAX_NESTING_DEF = 19;
    localparam int TOKEN_W         = 4;
    localparam int ERR_W           = 3;

    localparam logic [TOKEN_W-1:0] TK_LBRACE   = 4'd0;
    localparam logic [TOKEN_W-1:0] TK_RBRACE   = 4'd1;
    localparam logic [TOKEN_W-1:0] TK_LBRACKET = 4'd2;
    localparam logic [TOKEN_W-1:0] TK_RBRACKET = 4'd3;
    localparam logic [TOKEN_W-1:0] TK_COLON    = 4'd4;
    localparam logic [TOKEN_W-1:0] TK_COMMA    = 4'd5;
    localparam logic [TOKEN_W-1:0] TK_STRING   = 4'd6;
    localparam logic [TOKEN_W-1:0] TK_NULL     = 4'd10;

    typedef enum logic [2:0] {
        PH_ROOT      = 3'd0,
        PH_OBJ_FIRST = 3'd1,
        PH_OBJ_KEY   = 3'd2,
        PH_COLON     = 3'd3,
        PH_VALUE     = 3'd4,
        PH_ARR_FIRST = 3'd5,
        PH_AFTER     = 3'd6
    } t_phase;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE        = 3'd0,
        ERR_UNEXPECTED  = 3'd1,
        ERR_DEEP        = 3'd2,
        ERR_TRAILING    = 3'd3,
        ERR_EXTRA       = 3'd4,
        ERR_SCALAR_ROOT = 3'd5,
        ERR_INCOMPLETE  = 3'd6
    } t_err;

    typedef struct packed {
        logic push;
        logic pop;
        logic kind;
        logic clear;
    } t_stack_op;

    typedef struct packed {
        logic top;
        logic level_zero;
        logic level_one;
        logic full;
    } t_stack_stat;

    typedef struct packed {
        logic             ok_so_far;
        logic [ERR_W-1:0] error_code;
        logic             done_res;
        logic             valid_res;
    } t_result;

endpackage
`default_nettype wire

[rtl/jtsc_tok_if.sv]
// Token channel: valid/ready handshake carrying one token transaction.
`default_nettype none
interface jtsc_tok_if
    import jtsc_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [TOKEN_W-1:0] token;
    logic               last;

    modport source (output valid, output token, output last, input ready);
    modport sink   (input valid, input token, input last, output ready);
endinterface
`default_nettype wire

[rtl/jtsc_res_if.sv]
// Result channel: valid/ready handshake carrying one status transaction.
`default_nettype none
interface jtsc_res_if
    import jtsc_pkg::*;
;
    logic             valid;
    logic             ready;
    logic             ok_so_far;
    logic [ERR_W-1:0] error_code;
    logic             done_res;
    logic             valid_res;

    modport source (output valid, output ok_so_far, output error_code,
                    output done_res, output valid_res, input ready);
    modport sink   (input valid, input ok_so_far, input error_code,
                    input done_res, input valid_res, output ready);
endinterface
`default_nettype wire

[rtl/jtsc_stack.sv]
// Shift-register stack of open container kinds with its nesting level.
`default_nettype none
module jtsc_stack
    import jtsc_pkg::*;
#(
    parameter int MAX_NESTING = MAX_NESTING_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire t_stack_op   i_op,
    output t_stack_stat      o_stat
);

    localparam int LVL_W = $clog2(MAX_NESTING + 1);

    logic [MAX_NESTING-1:0] r_kind;
    logic [MAX_NESTING-1:0] n_kind;
    logic [LVL_W-1:0]       r_level;
    logic [LVL_W-1:0]       n_level;

    always_comb begin
        n_kind  = r_kind;
        n_level = r_level;
        if (i_op.clear) begin
            n_level = '0;
        end else if (i_op.push) begin
            n_kind[0] = i_op.kind;
            for (int i = 1; i < MAX_NESTING; i++) begin
                n_kind[i] = r_kind[i-1];
            end
            n_level = r_level + LVL_W'(1);
        end else if (i_op.pop) begin
            for (int i = 0; i < MAX_NESTING - 1; i++) begin
                n_kind[i] = r_kind[i+1];
            end
            n_level = r_level - LVL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
        end else begin
            r_level <= n_level;
        end
    end

    assign o_stat.top        = r_kind[0];
    assign o_stat.level_zero = (r_level == '0);
    assign o_stat.level_one  = (r_level == LVL_W'(1));
    assign o_stat.full       = (r_level >= LVL_W'(MAX_NESTING));

endmodule
`default_nettype wire

[rtl/jtsc_ctrl.sv]
// Grammar phase machine, error latch and status, one token per i_step.
`default_nettype none
module jtsc_ctrl
    import jtsc_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_step,
    input  wire  [TOKEN_W-1:0] i_token,
    input  wire                i_last,
    input  wire t_stack_stat   i_stat,
    output t_stack_op          o_op,
    output t_result            o_res
);

    `include "json_token_syntax_checker_unit_macros.svh"

    t_phase r_phase;
    t_phase n_phase;
    t_err   r_err;
    t_err   n_err;

    logic   is_scalar;
    logic   is_open;
    logic   close_ok;
    t_err   v_err;
    t_phase v_phase;
    logic   v_push;
    t_err   c_err;
    t_phase c_phase;
    t_err   a_err;
    t_phase a_phase;
    logic   a_push;
    logic   a_pop;
    t_err   cur_err;
    t_phase cur_phase;
    logic   zero_after;
    t_err   code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_ROOT;
            r_err   <= ERR_NONE;
        end else begin
            r_phase <= n_phase;
            r_err   <= n_err;
        end
    end

    always_comb begin
        is_scalar = (i_token >= TK_STRING) && (i_token <= TK_NULL);
        is_open   = (i_token == TK_LBRACE) || (i_token == TK_LBRACKET);
        close_ok  = !i_stat.level_zero &&
                    (i_token == (i_stat.top ? TK_RBRACKET : TK_RBRACE));

        // take a value: scalar, or open a container
        v_err   = ERR_NONE;
        v_phase = r_phase;
        v_push  = 1'b0;
        if (is_scalar) begin
            v_phase = PH_AFTER;
        end else if (is_open) begin
            if (i_stat.full) begin
                v_err = ERR_DEEP;
            end else begin
                v_push  = 1'b1;
                v_phase = (i_token == TK_LBRACKET) ? PH_ARR_FIRST : PH_OBJ_FIRST;
            end
        end else begin
            v_err = ERR_UNEXPECTED;
        end

        // close the innermost container
        c_err   = close_ok ? ERR_NONE : ERR_UNEXPECTED;
        c_phase = close_ok ? PH_AFTER : r_phase;

        a_err   = ERR_NONE;
        a_phase = r_phase;
        a_push  = 1'b0;
        a_pop   = 1'b0;
        unique case (r_phase)
            PH_ROOT: begin
                if (is_scalar) begin
                    a_err = ERR_SCALAR_ROOT;
                end else begin
                    a_err   = v_err;
                    a_phase = v_phase;
                    a_push  = v_push;
                end
            end
            PH_OBJ_FIRST: begin
                if (i_token == TK_RBRACE) begin
                    a_err   = c_err;
                    a_phase = c_phase;
                    a_pop   = close_ok;
                end else if (i_token == TK_STRING) begin
                    a_phase = PH_COLON;
                end else begin
                    a_err = ERR_UNEXPECTED;
                end
            end
            PH_OBJ_KEY: begin
                if (i_token == TK_RBRACE) begin
                    a_err = ERR_TRAILING;
                end else if (i_token == TK_STRING) begin
                    a_phase = PH_COLON;
                end else begin
                    a_err = ERR_UNEXPECTED;
                end
            end
            PH_COLON: begin
                if (i_token == TK_COLON) begin
                    a_phase = PH_VALUE;
                end else begin
                    a_err = ERR_UNEXPECTED;
                end
            end
            PH_VALUE: begin
                if (i_token == TK_RBRACKET && i_stat.top && !i_stat.level_zero) begin
                    a_err = ERR_TRAILING;
                end else begin
                    a_err   = v_err;
                    a_phase = v_phase;
                    a_push  = v_push;
                end
            end
            PH_ARR_FIRST: begin
                if (i_token == TK_RBRACKET) begin
                    a_err   = c_err;
                    a_phase = c_phase;
                    a_pop   = close_ok;
                end else begin
                    a_err   = v_err;
                    a_phase = v_phase;
                    a_push  = v_push;
                end
            end
            PH_AFTER: begin
                if (i_stat.level_zero) begin
                    a_err = ERR_EXTRA;
                end else if (i_token == TK_COMMA) begin
                    a_phase = i_stat.top ? PH_VALUE : PH_OBJ_KEY;
                end else begin
                    a_err   = c_err;
                    a_phase = c_phase;
                    a_pop   = close_ok;
                end
            end
            default: begin
                a_err = ERR_UNEXPECTED;
            end
        endcase

        // hold everything once an error is latched
        if (r_err != ERR_NONE) begin
            cur_err   = r_err;
            cur_phase = r_phase;
            a_push    = 1'b0;
            a_pop     = 1'b0;
        end else begin
            cur_err   = a_err;
            cur_phase = a_phase;
        end

        zero_after = (i_stat.level_zero && !a_push) || (i_stat.level_one && a_pop);
        code       = cur_err;
        if (i_last && cur_err == ERR_NONE && !(cur_phase == PH_AFTER && zero_after)) begin
            code = ERR_INCOMPLETE;
        end

        o_res.ok_so_far  = (code == ERR_NONE);
        o_res.error_code = code;
        o_res.done_res   = i_last;
        o_res.valid_res  = i_last && (code == ERR_NONE);

        o_op.push  = i_step && a_push;
        o_op.pop   = i_step && a_pop;
        o_op.kind  = (i_token == TK_LBRACKET);
        o_op.clear = i_step && i_last;

        n_phase = r_phase;
        n_err   = r_err;
        if (i_step) begin
            if (i_last) begin
                n_phase = PH_ROOT;
                n_err   = ERR_NONE;
            end else begin
                n_phase = cur_phase;
                n_err   = cur_err;
            end
        end
    end

    `JTSC_ASSERT_NEXT(a_err_hold, i_step && !i_last && r_err != ERR_NONE,
                      r_err == $past(r_err) && r_phase == $past(r_phase))
    `JTSC_ASSERT_NEXT(a_last_resets, i_step && i_last,
                      r_phase == PH_ROOT && r_err == ERR_NONE && i_stat.level_zero)
    `JTSC_ASSERT_SAME(a_root_phase, r_err == ERR_NONE && i_stat.level_zero,
                      r_phase == PH_ROOT || r_phase == PH_AFTER)
    `JTSC_ASSERT_SAME(a_no_push_pop, 1'b1, !(o_op.push && o_op.pop))

endmodule
`default_nettype wire

[rtl/json_token_syntax_checker_unit.sv]
// Top level of the JSON token syntax checker.
// Usage:
//   i_tok carries one token (code, last flag) per cycle while it is ready;
//   o_res returns exactly one status transaction per token, in order:
//   ok_so_far, error_code, done_res and, on the last token, valid_res.
//   The first grammar error is latched; later tokens leave it unchanged
//   until the token marked last, whose result carries the verdict and
//   returns the checker to its reset state for the next document.
// Timing:
//   An accepted token is held in the input register; the grammar step runs
//   from the input register straight into the result register.
//   Throughput is one token per cycle while o_res.ready stays high; the
//   stack push or pop and the phase update are done within each step.
// Reset and stall:
//   i_rst_n (synchronous, active low) empties the stack, clears the error
//   and sets the phase to expect the root value.
//   When the receiver holds o_res.ready low, the result register holds and
//   the input register fills; then i_tok.ready drops until the result drains.
`default_nettype none
module json_token_syntax_checker_unit
    import jtsc_pkg::*;
#(
    parameter int MAX_NESTING = MAX_NESTING_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    jtsc_tok_if.sink   i_tok,
    jtsc_res_if.source o_res
);

    logic               r_in_valid;
    logic [TOKEN_W-1:0] r_in_token;
    logic               r_in_last;
    logic               r_out_valid;
    t_result            r_out;

    logic               step;
    logic               in_accept;
    t_stack_op          stack_op;
    t_stack_stat        stack_stat;
    t_result            step_res;

    assign step        = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_tok.ready = !r_in_valid || step;
    assign in_accept   = i_tok.valid && i_tok.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_token <= i_tok.token;
            r_in_last  <= i_tok.last;
        end
    end

    jtsc_stack #(
        .MAX_NESTING(MAX_NESTING)
    ) u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (stack_op),
        .o_stat  (stack_stat)
    );

    jtsc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_token (r_in_token),
        .i_last  (r_in_last),
        .i_stat  (stack_stat),
        .o_op    (stack_op),
        .o_res   (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= step_res;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.ok_so_far  = r_out.ok_so_far;
    assign o_res.error_code = r_out.error_code;
    assign o_res.done_res   = r_out.done_res;
    assign o_res.valid_res  = r_out.valid_res;

endmodule
`default_nettype wire
